>>> rtl/sli_pkg.sv
`timescale 1ns / 1ps
package sli_pkg;
	localparam int MAX_LISTS_DEF  = 8;
	localparam int LIST_DEPTH_DEF = 64;
	localparam int RESULT_CAP     = 64;
	localparam logic [3:0] LIST_COUNT_RST   = 4'd2;
	localparam logic [6:0] RESULT_LIMIT_RST = 7'd64;

	typedef enum logic [0:0] {
		CMD_APPEND = 1'b0,
		CMD_RUN    = 1'b1
	} cmd_t;

	typedef enum logic [0:0] {
		REG_LIST_COUNT   = 1'b0,
		REG_RESULT_LIMIT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] match_value;
		logic        is_match;
		logic        last;
		logic [6:0]  match_count;
	} result_t;
endpackage

>>> rtl/sli_if.sv
`timescale 1ns / 1ps
interface sli_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [2:0]  list_id;
	logic [31:0] value;
	modport source (output valid, cmd, list_id, value, input ready);
	modport sink (input valid, cmd, list_id, value, output ready);
endinterface

interface sli_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] match_value;
	logic        is_match;
	logic        last;
	logic [6:0]  match_count;
	modport source (output valid, match_value, is_match, last, match_count, input ready);
	modport sink (input valid, match_value, is_match, last, match_count, output ready);
endinterface

interface sli_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/sli_store.sv
`timescale 1ns / 1ps
module sli_store #(
	parameter int AW = 9
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);
	logic [31:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/sorted_list_intersection_core.sv
`timescale 1ns / 1ps
// Append: a beat is accepted, then its length is updated in the append state; no result.
// Run: a round reads every head twice (find top, then align), each read then checked;
// a search probe is a read then a check, and a search ends in an exit state and a head
// re-read. A match passes through the emit state; the last result follows the end.
// The newest match is held back until the next one or the end of the run sets last.
// arst_n clears lengths, heads, config registers and control; the store holds no reset.
module sorted_list_intersection_core #(
	parameter int MAX_LISTS  = sli_pkg::MAX_LISTS_DEF,
	parameter int LIST_DEPTH = sli_pkg::LIST_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	sli_in_if.sink   in_ch,
	sli_out_if.source out_ch,
	sli_cfg_if.sink  cfg
);
	localparam int LW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
	localparam int DW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = LW + DW;
	localparam int NW = $clog2(MAX_LISTS + 1);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_APP   = 8'b00000010,
		ST_HRD   = 8'b00000100,
		ST_HCHK  = 8'b00001000,
		ST_SRD   = 8'b00010000,
		ST_SCHK  = 8'b00100000,
		ST_EMIT  = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	state_t state_q;
	logic [CW-1:0] len_q  [MAX_LISTS];
	logic [CW-1:0] head_q [MAX_LISTS];
	logic [3:0]  list_count_q;
	logic [6:0]  result_limit_q;
	logic [NW-1:0] n_q;
	logic [6:0]  limit_q, count_q;
	logic [LW-1:0] idx_q;
	logic        phase_q;   // 0: find top, 1: align heads
	logic [31:0] top_q;
	logic        all_eq_q;
	logic [CW-1:0] lo_q, hi_q;
	logic [2:0]  app_id_q;
	logic [31:0] app_val_q;
	logic        app_ok_q;
	logic        out_valid_q;
	sli_pkg::result_t res_q;
	sli_pkg::result_t pend_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   rdata;
	logic [CW-1:0] mid;

	sli_store #(.AW(AW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(app_val_q),
		.raddr(raddr), .rdata(rdata)
	);

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign we  = (state_q == ST_APP) && app_ok_q;
	assign waddr = {app_id_q[LW-1:0], len_q[app_id_q[LW-1:0]][DW-1:0]};

	always_comb begin
		if (state_q == ST_SRD) begin
			raddr = {idx_q, mid[DW-1:0]};
		end else begin
			raddr = {idx_q, head_q[idx_q][DW-1:0]};
		end
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;
	assign cfg.ready   = 1'b1;
	assign out_ch.valid       = out_valid_q;
	assign out_ch.match_value = res_q.match_value;
	assign out_ch.is_match    = res_q.is_match;
	assign out_ch.last        = res_q.last;
	assign out_ch.match_count = res_q.match_count;

	logic last_idx;
	assign last_idx = ({{(32-LW){1'b0}}, idx_q} + 32'd1) >= {{(32-NW){1'b0}}, n_q};

	// load the output register: a held match on a new one, or the final beat
	logic res_load;
	assign res_load = ((state_q == ST_EMIT && count_q != 7'd0) || state_q == ST_DONE) &&
		(!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < MAX_LISTS; i++) begin
				len_q[i]  <= '0;
				head_q[i] <= '0;
			end
			list_count_q   <= sli_pkg::LIST_COUNT_RST;
			result_limit_q <= sli_pkg::RESULT_LIMIT_RST;
			out_valid_q <= 1'b0;
			n_q <= '0; limit_q <= '0; count_q <= '0; idx_q <= '0;
			phase_q <= 1'b0; all_eq_q <= 1'b0; app_ok_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					sli_pkg::REG_LIST_COUNT:   list_count_q <= cfg.data[3:0];
					sli_pkg::REG_RESULT_LIMIT: result_limit_q <= cfg.data[6:0];
					default: ;
				endcase
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						if (in_ch.cmd == sli_pkg::CMD_APPEND) begin
							app_ok_q <= ({29'd0, in_ch.list_id} < MAX_LISTS) &&
								(32'(len_q[in_ch.list_id[LW-1:0]]) < LIST_DEPTH);
							state_q <= ST_APP;
						end else begin
							if (list_count_q == 4'd0) begin
								n_q <= NW'(1);
							end else if (32'(list_count_q) > MAX_LISTS) begin
								n_q <= NW'(MAX_LISTS);
							end else begin
								n_q <= NW'(list_count_q);
							end
							limit_q <= (result_limit_q > 7'd64) ? 7'd64 : result_limit_q;
							count_q <= '0;
							idx_q <= '0; phase_q <= 1'b0; top_q <= '0;
							state_q <= ST_HRD;
						end
					end
				end
				ST_APP: begin
					if (app_ok_q) begin
						len_q[app_id_q[LW-1:0]] <= len_q[app_id_q[LW-1:0]] + CW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_HRD: begin
					if (count_q >= limit_q) begin
						state_q <= ST_DONE;
					end else if (head_q[idx_q] >= len_q[idx_q]) begin
						// exhausted only matters while finding top
						if (!phase_q) begin
							state_q <= ST_DONE;
						end else begin
							all_eq_q <= 1'b0;
							if (last_idx) begin
								idx_q <= '0; phase_q <= 1'b0; top_q <= '0;
								state_q <= ST_HRD;
							end else idx_q <= idx_q + LW'(1);
						end
					end else begin
						state_q <= ST_HCHK;
					end
				end
				ST_HCHK: begin
					if (!phase_q) begin
						if (rdata > top_q) top_q <= rdata;
						if (last_idx) begin
							idx_q <= '0; phase_q <= 1'b1; all_eq_q <= 1'b1;
						end else idx_q <= idx_q + LW'(1);
						state_q <= ST_HRD;
					end else if (rdata < top_q) begin
						lo_q <= head_q[idx_q]; hi_q <= len_q[idx_q];
						state_q <= ST_SRD;
					end else begin
						if (rdata == top_q) begin
							head_q[idx_q] <= head_q[idx_q] + CW'(1);
						end else all_eq_q <= 1'b0;
						if (last_idx) begin
							idx_q <= '0; phase_q <= 1'b0;
							if (all_eq_q && rdata == top_q) begin
								state_q <= ST_EMIT;
							end else begin
								top_q <= '0;
								state_q <= ST_HRD;
							end
						end else begin
							idx_q <= idx_q + LW'(1);
							state_q <= ST_HRD;
						end
					end
				end
				ST_SRD: begin
					if (lo_q < hi_q) begin
						state_q <= ST_SCHK;
					end else begin
						// search done: head to lo, recheck entry there
						head_q[idx_q] <= lo_q;
						state_q <= ST_HRD;
					end
				end
				ST_SCHK: begin
					if (rdata < top_q) lo_q <= mid + CW'(1);
					else hi_q <= mid;
					state_q <= ST_SRD;
				end
				ST_EMIT: begin
					if (count_q == 7'd0 || res_load) begin
						if (count_q != 7'd0) begin
							res_q <= pend_q;
						end
						pend_q <= '{match_value: top_q, is_match: 1'b1, last: 1'b0,
							match_count: count_q + 7'd1};
						count_q <= count_q + 7'd1;
						top_q <= '0;
						state_q <= ST_HRD;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						if (count_q == 7'd0) begin
							res_q <= '{match_value: 32'd0, is_match: 1'b0, last: 1'b1,
								match_count: 7'd0};
						end else begin
							res_q <= '{match_value: pend_q.match_value, is_match: 1'b1,
								last: 1'b1, match_count: pend_q.match_count};
						end
						for (int i = 0; i < MAX_LISTS; i++) begin
							len_q[i]  <= '0;
							head_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			app_id_q  <= in_ch.list_id;
			app_val_q <= in_ch.value;
		end
	end
endmodule

>>> rtl/sli_checker.sv
`timescale 1ns / 1ps
module sli_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid, in_ready,
	input logic out_valid, out_ready, out_is_match, out_last,
	input logic [6:0] out_match_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_is_match |-> out_last && out_match_count == 7'd0)
		else $error("bad empty marker");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_is_match |-> out_match_count != 7'd0)
		else $error("match count zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accepting while result pending");
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("back to back input beats");
endmodule

bind sorted_list_intersection_core sli_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_is_match(out_ch.is_match), .out_last(out_ch.last),
	.out_match_count(out_ch.match_count)
);
